// ----- hw/rtl/dnle_pkg.sv -----
// ----------------------------------------------------------------------------
// dnle_pkg
// Shared types and constants of the DNS name label encoder.
// ----------------------------------------------------------------------------
package dnle_pkg;

  // Width of a label length; covers every supported label capacity (up to 63).
  localparam int CNT_W = 6;

  localparam logic [7:0] DOT_CHAR  = 8'h2E;
  localparam logic [7:0] ZERO_BYTE = 8'h00;

  // One flush job handed from the front to the back.
  typedef struct packed {
    logic             bank;     // label bank that holds the characters
    logic [CNT_W-1:0] count;    // characters held in that bank
    logic             ovf;      // label lost characters to the capacity limit
    logic             fin;      // name ends after this label
    logic             fin_dot;  // name ended in a dot: add an empty label
  } cmd_t;

  // Bank release from the back once a job is fully emitted.
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEN,
    S_DATA,
    S_EMPTY,
    S_TERM
  } back_state_t;

endpackage

// ----- hw/rtl/dnle_char_if.sv -----
// ----------------------------------------------------------------------------
// dnle_char_if
// Input channel: one name character per transfer.
// ----------------------------------------------------------------------------
interface dnle_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       is_final;

  modport source (output valid, output ch, output is_final, input ready);
  modport sink   (input valid, input ch, input is_final, output ready);
endinterface

// ----- hw/rtl/dnle_byte_if.sv -----
// ----------------------------------------------------------------------------
// dnle_byte_if
// Output channel: one wire-format byte per transfer.
// ----------------------------------------------------------------------------
interface dnle_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       end_of_name;
  logic       label_overflow;

  modport source (output valid, output out_byte, output last_of_run,
                  output end_of_name, output label_overflow, input ready);
  modport sink   (input valid, input out_byte, input last_of_run,
                  input end_of_name, input label_overflow, output ready);
endinterface

// ----- hw/rtl/dnle_ram.sv -----
// ----------------------------------------------------------------------------
// dnle_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module dnle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/dnle_front.sv -----
// ----------------------------------------------------------------------------
// dnle_front
// Accepts characters, stores ordinary ones in the current label bank and
// issues a flush job on a dot or on the final character.
// ----------------------------------------------------------------------------
module dnle_front import dnle_pkg::*; #(
  parameter int MAX_LABEL = 32
) (
  input  logic clk,
  input  logic rst,
  dnle_char_if.sink chars,
  output logic q_valid,
  input  logic q_ready,
  output cmd_t q_cmd,
  input  rel_t rel,
  output logic wr_en,
  output logic [((MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1):0] wr_addr,
  output logic [7:0] wr_data
);

  localparam int IDXW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

  logic             bank;
  logic [CNT_W-1:0] count;
  logic             ovf;
  logic [1:0]       busy;
  logic [1:0]       busy_next;

  logic acc;
  logic dot;
  logic room;
  logic flush;

  assign chars.ready = !busy[bank] && q_ready;
  assign acc   = chars.valid && chars.ready;
  assign dot   = (chars.ch == DOT_CHAR);
  assign room  = (count < CNT_W'(MAX_LABEL));
  assign flush = acc && (dot || chars.is_final);

  // Ordinary characters, the final one included, go into the bank while it has room.
  assign wr_en   = acc && !dot && room;
  assign wr_addr = {bank, count[IDXW-1:0]};
  assign wr_data = chars.ch;

  always_comb begin
    q_valid       = flush;
    q_cmd.bank    = bank;
    q_cmd.count   = (!dot && room) ? count + 1'b1 : count;
    q_cmd.ovf     = ovf || (!dot && !room);
    q_cmd.fin     = chars.is_final;
    q_cmd.fin_dot = chars.is_final && dot;

    busy_next = busy;
    if (rel.valid) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (flush) begin
      busy_next[bank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank  <= 1'b0;
      count <= '0;
      ovf   <= 1'b0;
      busy  <= '0;
    end else begin
      busy <= busy_next;
      if (flush) begin
        bank  <= !bank;
        count <= '0;
        ovf   <= 1'b0;
      end else if (acc) begin
        if (room) begin
          count <= count + 1'b1;
        end else begin
          ovf <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/dnle_cmdq.sv -----
// ----------------------------------------------------------------------------
// dnle_cmdq
// Two-entry queue of flush jobs between front and back.
// ----------------------------------------------------------------------------
module dnle_cmdq import dnle_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t       slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_cmd    = slots[rp];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wp <= !wp;
      end
      if (pop) begin
        rp <= !rp;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

// ----- hw/rtl/dnle_back.sv -----
// ----------------------------------------------------------------------------
// dnle_back
// Runs flush jobs: length byte, label bytes from the bank, optional empty
// label and terminator, through a registered output stage.
// ----------------------------------------------------------------------------
module dnle_back import dnle_pkg::*; #(
  parameter int MAX_LABEL = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  cmd_t q_cmd,
  output logic rd_en,
  output logic [((MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1):0] rd_addr,
  input  logic [7:0] rd_data,
  output rel_t rel,
  dnle_byte_if.source bytes
);

  localparam int IDXW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

  back_state_t      state;
  back_state_t      state_next;
  back_state_t      tail;
  cmd_t             cmd;
  cmd_t             cmd_next;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] pos_next;
  logic [CNT_W-1:0] pos_inc;
  logic             at_end;

  logic       adv;
  logic       emit;
  logic [7:0] e_byte;
  logic       e_last;
  logic       e_eon;
  logic       e_ovf;

  logic       o_valid;
  logic [7:0] o_byte;
  logic       o_last;
  logic       o_eon;
  logic       o_ovf;

  assign bytes.valid          = o_valid;
  assign bytes.out_byte       = o_byte;
  assign bytes.last_of_run    = o_last;
  assign bytes.end_of_name    = o_eon;
  assign bytes.label_overflow = o_ovf;

  assign adv     = !o_valid || bytes.ready;
  assign pos_inc = pos + 1'b1;
  assign at_end  = (pos_inc == cmd.count);

  always_comb begin
    state_next = state;
    cmd_next   = cmd;
    pos_next   = pos;
    q_ready    = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = {cmd.bank, pos_inc[IDXW-1:0]};
    emit       = 1'b0;
    e_byte     = ZERO_BYTE;
    e_last     = 1'b0;
    e_eon      = 1'b0;
    e_ovf      = 1'b0;

    if (cmd.fin_dot) begin
      tail = S_EMPTY;
    end else if (cmd.fin) begin
      tail = S_TERM;
    end else begin
      tail = S_IDLE;
    end

    unique case (state)
      S_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          cmd_next   = q_cmd;
          pos_next   = '0;
          state_next = S_LEN;
        end
      end
      S_LEN: begin
        if (adv) begin
          emit    = 1'b1;
          e_byte  = {{(8 - CNT_W){1'b0}}, cmd.count};
          e_last  = !cmd.fin && (cmd.count == '0);
          e_ovf   = cmd.ovf;
          rd_en   = 1'b1;
          rd_addr = {cmd.bank, {IDXW{1'b0}}};
          pos_next = '0;
          if (cmd.count == '0) begin
            state_next = tail;
          end else begin
            state_next = S_DATA;
          end
        end
      end
      S_DATA: begin
        if (adv) begin
          emit     = 1'b1;
          e_byte   = rd_data;
          e_last   = !cmd.fin && at_end;
          e_ovf    = cmd.ovf;
          rd_en    = 1'b1;
          pos_next = pos_inc;
          if (at_end) begin
            state_next = tail;
          end
        end
      end
      S_EMPTY: begin
        if (adv) begin
          emit       = 1'b1;
          state_next = S_TERM;
        end
      end
      S_TERM: begin
        if (adv) begin
          emit       = 1'b1;
          e_last     = 1'b1;
          e_eon      = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    rel.valid = (state != S_IDLE) && (state_next == S_IDLE);
    rel.bank  = cmd.bank;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (adv) begin
        o_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd <= cmd_next;
    pos <= pos_next;
    if (adv) begin
      o_byte <= e_byte;
      o_last <= e_last;
      o_eon  <= e_eon;
      o_ovf  <= e_ovf;
    end
  end

endmodule

// ----- hw/rtl/dns_name_label_encoder_core.sv -----
// ----------------------------------------------------------------------------
// dns_name_label_encoder_core
// Converts a dotted domain name, one character per transfer, to DNS wire
// format: length-prefixed labels followed by a zero terminator.
// ----------------------------------------------------------------------------
// Usage: feed the name on name_chars, flagging the last character with
// is_final; collect bytes on wire_bytes. Ordinary characters produce no
// output and are taken one per cycle while the current label bank is free.
// A dot, or the final character, hands the held label to the back end,
// which sends its length byte and then its characters at one byte per cycle
// while wire_bytes is ready; a final character adds the terminator (after
// an extra empty label if the name ends in a dot). Labels longer than
// MAX_LABEL keep their first MAX_LABEL characters and carry label_overflow on
// all their bytes. Two label banks in one RAM let the front collect the next
// label while the back drains the previous one; the front waits only when the
// bank it needs is still being drained. For each job the back end first picks
// it up from the queue, then sends the length byte and the characters; a name
// end adds the terminator, preceded by the empty label when the name ends in
// a dot. With the back end idle, the job of the closing character passes
// through the job queue and the back end's pick-up before the length byte is
// registered on the output. Sustained, the back end sends one output byte per
// cycle while wire_bytes is ready, apart from picking up each new job. The
// label RAM needs no clearing after reset.
// ----------------------------------------------------------------------------
module dns_name_label_encoder_core import dnle_pkg::*; #(
  parameter int MAX_LABEL = 32
) (
  input  logic clk,
  input  logic rst,
  dnle_char_if.sink   name_chars,
  dnle_byte_if.source wire_bytes
);

  localparam int IDXW  = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
  localparam int AW    = IDXW + 1;
  localparam int DEPTH = 2 << IDXW;

  // front -> queue
  logic   push_valid;
  logic   push_ready;
  cmd_t   push_cmd;
  // queue -> back
  logic   pop_valid;
  logic   pop_ready;
  cmd_t   pop_cmd;
  // back -> front: bank drained, free to refill
  rel_t   rel;

  // label RAM ports: front writes, back reads
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  // Classify characters, hold label bytes, issue flush jobs.
  dnle_front #(
    .MAX_LABEL(MAX_LABEL)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .chars  (name_chars),
    .q_valid(push_valid),
    .q_ready(push_ready),
    .q_cmd  (push_cmd),
    .rel    (rel),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  // Decouple the two sides; at most one job per bank is ever pending.
  dnle_cmdq u_cmdq (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_cmd  (push_cmd),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd)
  );

  // Two label banks; bank select is the top address bit.
  dnle_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_label_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // Emit length, label bytes and terminator through the output register.
  dnle_back #(
    .MAX_LABEL(MAX_LABEL)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(pop_valid),
    .q_ready(pop_ready),
    .q_cmd  (pop_cmd),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .rel    (rel),
    .bytes  (wire_bytes)
  );

endmodule

// ----- bench/dns_name_label_encoder_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dns_name_label_encoder_core_tb
// Self-checking bench for the DNS name label encoder core.
// ----------------------------------------------------------------------------
// Names go in one character per transfer and wire-format bytes come out. A
// scoreboard mirrors the label store. On every accepted character it works out
// the bytes that character releases and queues them. Each accepted output byte
// is checked against the oldest queued byte, field by field. The bench runs a
// short directed set of names first. It then runs randomized names, labels
// longer than the capacity, and loose characters. Both sides insert random
// gaps. The receiver holds off for long stretches so that the label banks back
// up, and the sender now and then waits until the output has drained.
// ----------------------------------------------------------------------------
module dns_name_label_encoder_core_tb;
  import dnle_pkg::*;

  localparam int MAX_LABEL    = 32;
  localparam int ITEM_TARGET  = 150;   // characters after the directed set
  localparam int MAX_GAP      = 18;
  localparam int LONG_HOLD    = 400;   // receiver hold-off, in cycles
  localparam int STALL_LIMIT  = 4000;  // cycles with no transfer at all
  localparam int DRAIN_CYCLES = 60;

  // How a generated name ends: on an ordinary final character, on a final dot, or either at random.
  typedef enum int {END_ANY, END_CHAR, END_DOT} name_end_t;

  // One wire-format byte with its side flags.
  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       eon;
    logic       ovf;
  } wire_byte_t;

  // --------------------------------------------------------------------------
  // Scoreboard: label-store mirror plus the queue of bytes still due.
  // --------------------------------------------------------------------------
  class label_scoreboard;
    bit [7:0]   held [MAX_LABEL];
    int         held_n;
    bit         lost;
    wire_byte_t due [$];
    int         errors;

    function new();
      held_n = 0;
      lost   = 1'b0;
      errors = 0;
    endfunction

    task report(string what);
      if (errors < 40) $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    function void push_byte(logic [7:0] b, logic last, logic eon, logic ovf);
      wire_byte_t e;
      e.b    = b;
      e.last = last;
      e.eon  = eon;
      e.ovf  = ovf;
      due.push_back(e);
    endfunction

    // Keep the character if there is room, else mark the label as clipped.
    function void hold_char(logic [7:0] c);
      if (held_n < MAX_LABEL) begin
        held[held_n] = c;
        held_n++;
      end else begin
        lost = 1'b1;
      end
    endfunction

    // Queue length byte and characters of the held label, then clear it.
    // ends_run puts last_of_run on the final byte of the label.
    function void flush_label(bit ends_run);
      int n;
      n = held_n;
      push_byte(8'(n), ends_run && (n == 0), 1'b0, lost);
      for (int i = 0; i < n; i++)
        push_byte(held[i], ends_run && (i == n - 1), 1'b0, lost);
      held_n = 0;
      lost   = 1'b0;
    endfunction

    // Note an accepted character and queue the bytes it releases.
    function void note_char(logic [7:0] c, logic fin);
      if (!fin) begin
        if (c != DOT_CHAR) hold_char(c);
        else flush_label(1'b1);
      end else begin
        if (c == DOT_CHAR) begin
          flush_label(1'b0);
          push_byte(ZERO_BYTE, 1'b0, 1'b0, 1'b0);  // trailing empty label
        end else begin
          hold_char(c);
          flush_label(1'b0);
        end
        push_byte(ZERO_BYTE, 1'b1, 1'b1, 1'b0);    // terminator
      end
    endfunction

    // Check one accepted output byte against the oldest byte still due.
    task check_byte(wire_byte_t got);
      wire_byte_t want;
      if (due.size() == 0) begin
        report($sformatf("unexpected byte %02h", got.b));
      end else begin
        want = due.pop_front();
        if (got.b !== want.b)
          report($sformatf("out_byte %02h, want %02h", got.b, want.b));
        if (got.last !== want.last)
          report($sformatf("last_of_run %b, want %b (byte %02h)", got.last, want.last, want.b));
        if (got.eon !== want.eon)
          report($sformatf("end_of_name %b, want %b (byte %02h)", got.eon, want.eon, want.b));
        if (got.ovf !== want.ovf)
          report($sformatf("label_overflow %b, want %b (byte %02h)", got.ovf, want.ovf, want.b));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels, block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  dnle_char_if name_chars ();
  dnle_byte_if wire_bytes ();

  dns_name_label_encoder_core #(
    .MAX_LABEL (MAX_LABEL)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .name_chars (name_chars),
    .wire_bytes (wire_bytes)
  );

  label_scoreboard sb = new();

  int chars_sent = 0;
  int send_calm  = 0;
  int recv_calm  = 0;
  bit hold_req   = 1'b1;  // the receiver starts with a long hold-off
  int idle_cycles = 0;

  // Gap before the next transfer. Now and then start a run of back-to-back
  // transfers so that stretches with no idling show up as well.
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(8, 30);
    return $urandom_range(0, MAX_GAP);
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // Offer one character after a random gap and hold it until it transfers.
  // Always entered and left at a rising edge, so valid sees one update per step.
  task automatic send_char(logic [7:0] c, logic fin);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      name_chars.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    name_chars.valid    <= 1'b1;
    name_chars.ch       <= c;
    name_chars.is_final <= fin;
    do @(posedge clk); while (!(name_chars.valid && name_chars.ready));
    sb.note_char(c, fin);
    chars_sent++;
  endtask

  // Drop valid and wait until every queued byte has come out.
  task automatic pause_until_drained();
    name_chars.valid <= 1'b0;
    do @(posedge clk); while (sb.due.size() != 0);
  endtask

  // Any byte except the separator.
  function automatic logic [7:0] label_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == DOT_CHAR) c = 8'h2D;
    return c;
  endfunction

  // Mostly short labels, some mid-size, a few at or past the capacity.
  function automatic int draw_label_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 8);
    if (r < 9) return $urandom_range(9, MAX_LABEL - 1);
    return $urandom_range(MAX_LABEL, MAX_LABEL + 4);
  endfunction

  // Send one well-formed name. last_len >= 0 sends a single label of that
  // length; last_len < 0 sends one to four labels of drawn length. end_kind
  // picks the closing form.
  task automatic send_name(int last_len, name_end_t end_kind);
    int nlab;
    int len;
    bit dot_end;
    nlab = (last_len >= 0) ? 1 : $urandom_range(1, 4);
    for (int l = 0; l < nlab; l++) begin
      len = (l == nlab - 1 && last_len >= 0) ? last_len : draw_label_len();
      if (l < nlab - 1) begin
        repeat (len) send_char(label_char(), 1'b0);
        send_char(DOT_CHAR, 1'b0);
      end else begin
        dot_end = (end_kind == END_DOT) || (len == 0) ||
                  (end_kind == END_ANY && $urandom_range(0, 4) == 0);
        if (dot_end) begin
          repeat (len) send_char(label_char(), 1'b0);
          send_char(DOT_CHAR, 1'b1);
        end else begin
          repeat (len - 1) send_char(label_char(), 1'b0);
          send_char(label_char(), 1'b1);
        end
      end
    end
  endtask

  // Loose character: dots and final flags at random, names left half open.
  task automatic send_noise();
    logic [7:0] c;
    c = ($urandom_range(0, 3) == 0) ? DOT_CHAR : 8'($urandom_range(0, 255));
    send_char(c, $urandom_range(0, 7) == 0);
  endtask

  initial begin : name_source
    bit hold_done;
    hold_done           = 1'b0;
    name_chars.valid    = 1'b0;
    name_chars.ch       = 8'h00;
    name_chars.is_final = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed names. The receiver is holding off here, so they back up.
    // Label with the extreme byte values, closed by a plain dot.
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(DOT_CHAR, 1'b0);
    // Empty label from a lone dot.
    send_char(DOT_CHAR, 1'b0);
    // Final dot after a label: extra empty label before the terminator.
    send_char(8'h61, 1'b0);
    send_char(8'h62, 1'b0);
    send_char(DOT_CHAR, 1'b1);
    // Name that is a single final dot.
    send_char(DOT_CHAR, 1'b1);
    // Single final character, then a zero byte as the final character.
    send_char(8'h78, 1'b1);
    send_char(8'h00, 1'b1);
    // Repeated leading dots, then a label with bytes next to the dot value.
    send_char(DOT_CHAR, 1'b0);
    send_char(DOT_CHAR, 1'b0);
    send_char(8'h2D, 1'b0);
    send_char(8'h2F, 1'b0);
    send_char(8'h55, 1'b0);
    send_char(8'hAA, 1'b0);
    send_char(8'h7A, 1'b1);
    pause_until_drained();

    // Capacity edges: a full label, a final character that gets dropped,
    // and a clipped label closed by a final dot.
    chars_sent = 0;
    send_name(MAX_LABEL, END_CHAR);
    send_name(MAX_LABEL + 1, END_CHAR);
    send_name(MAX_LABEL + 3, END_DOT);

    // Random phase: mostly well-formed names, some loose characters.
    while (chars_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) < 8) send_name(-1, END_ANY);
      else repeat ($urandom_range(1, 6)) send_noise();
      if ($urandom_range(0, 7) == 0) pause_until_drained();
      if (!hold_done && chars_sent > ITEM_TARGET / 2) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
    end

    // Wind down: let the output drain, then allow for stray late bytes.
    name_chars.valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver side: random ready gaps, long hold-off on request, and a check
  // of every transfer.
  // --------------------------------------------------------------------------
  initial begin : byte_sink
    int gap;
    wire_byte_t got;
    wire_bytes.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req) begin
        gap      = LONG_HOLD;
        hold_req = 1'b0;
      end else begin
        gap = draw_gap(recv_calm);
      end
      if (gap > 0) begin
        wire_bytes.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      wire_bytes.ready <= 1'b1;
      do @(posedge clk); while (!(wire_bytes.valid && wire_bytes.ready));
      got.b    = wire_bytes.out_byte;
      got.last = wire_bytes.last_of_run;
      got.eon  = wire_bytes.end_of_name;
      got.ovf  = wire_bytes.label_overflow;
      sb.check_byte(got);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if neither channel moves for too long.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (name_chars.valid && name_chars.ready) ||
        (wire_bytes.valid && wire_bytes.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule
